// ===== src/assert_macros.svh =====
// Assertion macros used by the checker datapath, bsoc_dp.
// Define ASSERT_OFF to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== src/bsoc_pkg.sv =====
// Shared constants and types of the box/sphere obstacle checker.
// No dependencies.
`timescale 1ns / 1ps
package bsoc_pkg;
   localparam int MaxObstacles = 32;
   localparam int CoordBits    = 24;
   localparam int CsrIndexBits = 3;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_CHECK  = 2'd1;
   localparam logic [1:0] OP_SENSE  = 2'd2;
   localparam logic [1:0] OP_EXISTS = 2'd3;

   localparam logic [CsrIndexBits-1:0] CSR_MIN_X = 3'd0;
   localparam logic [CsrIndexBits-1:0] CSR_MIN_Y = 3'd1;
   localparam logic [CsrIndexBits-1:0] CSR_MIN_Z = 3'd2;
   localparam logic [CsrIndexBits-1:0] CSR_MAX_X = 3'd3;
   localparam logic [CsrIndexBits-1:0] CSR_MAX_Y = 3'd4;
   localparam logic [CsrIndexBits-1:0] CSR_MAX_Z = 3'd5;

   typedef struct packed {
      logic load;
      logic issue;
      logic final_emit;
   } cmd_type;

   typedef struct packed {
      logic       adv;
      logic       walk_done;
      logic       pipe_empty;
      logic       out_free;
      logic [1:0] op;
   } status_type;
endpackage

// ===== src/bsoc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module bsoc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== src/bsoc_ctrl.sv =====
// Checker sequencer: accept, walk the table unless adding, deliver the final result.
// Depends on bsoc_pkg.
`timescale 1ns / 1ps
module bsoc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bsoc_pkg::status_type status,
   output bsoc_pkg::cmd_type    cmd
);
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WALK  = 2'd1;
   localparam logic [1:0] ST_FINAL = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in       = state_ff;
      cmd.load       = 1'b0;
      cmd.issue      = 1'b0;
      cmd.final_emit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (status.op == bsoc_pkg::OP_ADD) begin
               state_in = ST_FINAL;
            end else begin
               cmd.issue = status.adv && !status.walk_done;
               if (status.walk_done && status.pipe_empty) begin
                  state_in = ST_FINAL;
               end
            end
         end
         ST_FINAL: begin
            if (status.out_free) begin
               cmd.final_emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
endmodule

// ===== src/bsoc_dp.sv =====
// Datapath: world bounds, obstacle table, distance pipeline, pending and output registers.
// Depends on bsoc_pkg, bsoc_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bsoc_dp #(
   parameter int MAX_OBSTACLES = bsoc_pkg::MaxObstacles,
   parameter int COORD_BITS    = bsoc_pkg::CoordBits
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [1:0]                        req_operation,
   input  logic signed [COORD_BITS-1:0]      req_pos_x,
   input  logic signed [COORD_BITS-1:0]      req_pos_y,
   input  logic signed [COORD_BITS-1:0]      req_pos_z,
   input  logic [COORD_BITS-2:0]             req_radius_in,
   input  logic [COORD_BITS-2:0]             req_half_width_x,
   input  logic [COORD_BITS-2:0]             req_half_width_y,
   input  logic [COORD_BITS-2:0]             req_half_width_z,
   input  logic                              csr_write_enable,
   input  logic [bsoc_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [COORD_BITS-1:0]             csr_write_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_answer,
   output logic signed [COORD_BITS-1:0]      rsp_found_x,
   output logic signed [COORD_BITS-1:0]      rsp_found_y,
   output logic signed [COORD_BITS-1:0]      rsp_found_z,
   output logic [COORD_BITS-2:0]             rsp_found_radius,
   output logic                              rsp_last,
   output logic                              rsp_table_full,
   input  bsoc_pkg::cmd_type                 cmd,
   output bsoc_pkg::status_type              status
);
   localparam int CB   = COORD_BITS;
   localparam int AW   = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
   localparam int CNTW = $clog2(MAX_OBSTACLES + 1);
   localparam int EW   = 4 * CB - 1;
   localparam int SQW  = 2 * CB;

   // world bounds
   logic signed [CB-1:0] wmin_ff [3];
   logic signed [CB-1:0] wmax_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            wmin_ff[a] <= '0;
            wmax_ff[a] <= '0;
         end
      end else if (csr_write_enable) begin
         case (csr_index)
            bsoc_pkg::CSR_MIN_X: wmin_ff[0] <= csr_write_data;
            bsoc_pkg::CSR_MIN_Y: wmin_ff[1] <= csr_write_data;
            bsoc_pkg::CSR_MIN_Z: wmin_ff[2] <= csr_write_data;
            bsoc_pkg::CSR_MAX_X: wmax_ff[0] <= csr_write_data;
            bsoc_pkg::CSR_MAX_Y: wmax_ff[1] <= csr_write_data;
            bsoc_pkg::CSR_MAX_Z: wmax_ff[2] <= csr_write_data;
            default: ;
         endcase
      end
   end

   // request capture
   logic [1:0]             op_ff;
   logic signed [CB-1:0]   p_ff  [3];
   logic [CB-2:0]          rad_ff;
   logic signed [CB:0]     lo_ff [3];
   logic signed [CB:0]     hi_ff [3];
   logic                   bounds_ok_ff, bounds_ok_in;
   logic signed [CB-1:0]   p_in  [3];
   logic [CB-2:0]          hw_in [3];

   assign p_in[0] = req_pos_x;
   assign p_in[1] = req_pos_y;
   assign p_in[2] = req_pos_z;
   assign hw_in[0] = req_half_width_x;
   assign hw_in[1] = req_half_width_y;
   assign hw_in[2] = req_half_width_z;

   always_comb begin
      logic signed [CB+1:0] lo_b, hi_b, pe;
      bounds_ok_in = 1'b1;
      for (int a = 0; a < 3; a++) begin
         pe   = (CB+2)'(p_in[a]);
         lo_b = (CB+2)'(wmin_ff[a]) + $signed({3'b000, hw_in[a]});
         hi_b = (CB+2)'(wmax_ff[a]) - $signed({3'b000, hw_in[a]});
         if (pe < lo_b || pe > hi_b) begin
            bounds_ok_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff        <= req_operation;
         rad_ff       <= req_radius_in;
         bounds_ok_ff <= bounds_ok_in;
         for (int a = 0; a < 3; a++) begin
            p_ff[a]  <= p_in[a];
            lo_ff[a] <= (CB+1)'(p_in[a]) - $signed({2'b00, hw_in[a]});
            hi_ff[a] <= (CB+1)'(p_in[a]) + $signed({2'b00, hw_in[a]});
         end
      end
   end

   // obstacle table
   logic [CNTW-1:0] count_ff, count_in;
   logic [CNTW-1:0] idx_ff;
   logic            full;
   logic            ram_we;
   logic [EW-1:0]   ram_wdata, ram_rdata;
   logic [CB-2:0]   rad_raised;
   logic            adv;

   assign full       = (count_ff == CNTW'(MAX_OBSTACLES));
   assign ram_we     = cmd.final_emit && (op_ff == bsoc_pkg::OP_ADD) && !full;
   assign rad_raised = (rad_ff == '0) ? (CB-1)'(1) : rad_ff;
   assign ram_wdata  = {rad_raised, p_ff[2], p_ff[1], p_ff[0]};
   assign count_in   = ram_we ? count_ff + CNTW'(1) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         if (cmd.load) begin
            idx_ff <= '0;
         end else if (cmd.issue) begin
            idx_ff <= idx_ff + CNTW'(1);
         end
      end
   end

   bsoc_ram #(.WIDTH(EW), .DEPTH(MAX_OBSTACLES), .AW(AW)) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[AW-1:0]),
      .wdata (ram_wdata),
      .re    (adv),
      .raddr (idx_ff[AW-1:0]),
      .rdata (ram_rdata)
   );

   // distance pipeline
   logic v0_ff, va_ff, vb_ff, vc_ff;
   logic [EW-1:0] ea_ff, eb_ff, ec_ff;
   logic eqa_ff, eqb_ff, eqc_ff;
   logic [CB+1:0] ma_ff [3];
   logic [CB-1:0] ra_ff;
   logic          nearb_ff;
   logic [SQW-1:0] sq_ff [3];
   logic [SQW-1:0] rr_ff;
   logic           near_in;
   logic [CB+1:0]  ma_in [3];
   logic [CB-1:0]  ra_in;
   logic           eqa_in;
   logic [SQW+1:0] sum;
   logic           hitc;
   logic           is_sense;

   always_comb begin
      logic signed [CB-1:0] c;
      logic signed [CB:0]   cl;
      logic signed [CB+1:0] d;
      logic [CB-2:0]        r;
      r = ram_rdata[EW-1:3*CB];
      eqa_in = (r == rad_ff);
      for (int a = 0; a < 3; a++) begin
         c = ram_rdata[a*CB +: CB];
         cl = '0;
         eqa_in = eqa_in && (c == p_ff[a]);
         if (op_ff == bsoc_pkg::OP_CHECK) begin
            if ((CB+1)'(c) < lo_ff[a]) begin
               cl = lo_ff[a];
            end else if ((CB+1)'(c) > hi_ff[a]) begin
               cl = hi_ff[a];
            end else begin
               cl = (CB+1)'(c);
            end
            d = (CB+2)'(cl) - (CB+2)'(c);
         end else begin
            d = (CB+2)'(p_ff[a]) - (CB+2)'(c);
         end
         ma_in[a] = d[CB+1] ? (CB+2)'(-d) : (CB+2)'(d);
      end
      if (op_ff == bsoc_pkg::OP_SENSE) begin
         ra_in = CB'(r) + CB'(rad_ff);
      end else begin
         ra_in = CB'(r);
      end
   end

   assign near_in = (ma_ff[0] <= (CB+2)'(ra_ff)) && (ma_ff[1] <= (CB+2)'(ra_ff)) &&
                    (ma_ff[2] <= (CB+2)'(ra_ff));

   always_ff @(posedge clock) begin
      if (adv) begin
         ea_ff  <= ram_rdata;
         eqa_ff <= eqa_in;
         ra_ff  <= ra_in;
         for (int a = 0; a < 3; a++) begin
            ma_ff[a] <= ma_in[a];
         end
         eb_ff    <= ea_ff;
         eqb_ff   <= eqa_ff;
         nearb_ff <= near_in;
         for (int a = 0; a < 3; a++) begin
            sq_ff[a] <= ma_ff[a][CB-1:0] * ma_ff[a][CB-1:0];
         end
         rr_ff  <= ra_ff * ra_ff;
         ec_ff  <= eb_ff;
         eqc_ff <= eqb_ff;
      end
   end

   logic nearc_ff;
   logic [SQW-1:0] sqc_ff [3];
   logic [SQW-1:0] rrc_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         nearc_ff <= nearb_ff;
         rrc_ff   <= rr_ff;
         for (int a = 0; a < 3; a++) begin
            sqc_ff[a] <= sq_ff[a];
         end
      end
   end

   assign sum  = (SQW+2)'(sqc_ff[0]) + (SQW+2)'(sqc_ff[1]) + (SQW+2)'(sqc_ff[2]);
   assign hitc = vc_ff && nearc_ff && (sum <= (SQW+2)'(rrc_ff));
   assign is_sense = (op_ff == bsoc_pkg::OP_SENSE);

   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         v0_ff <= 1'b0;
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= cmd.issue;
         va_ff <= v0_ff;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   // verdict flags and pending sense hit
   logic collide_ff, match_ff, pend_v_ff;
   logic [EW-1:0] pend_ff;
   logic out_free, mid_emit;

   assign out_free = !rsp_valid || !rsp_stall;
   assign adv      = !(hitc && is_sense && pend_v_ff && !out_free);
   assign mid_emit = hitc && is_sense && pend_v_ff && out_free;

   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         collide_ff <= 1'b0;
         match_ff   <= 1'b0;
         pend_v_ff  <= 1'b0;
      end else if (adv) begin
         if (hitc && (op_ff == bsoc_pkg::OP_CHECK)) begin
            collide_ff <= 1'b1;
         end
         if (vc_ff && eqc_ff) begin
            match_ff <= 1'b1;
         end
         if (hitc && is_sense) begin
            pend_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && hitc && is_sense) begin
         pend_ff <= ec_ff;
      end
   end

   // output register
   logic          rsp_valid_ff;
   logic          ans_ff, last_ff, tfull_ff;
   logic [EW-1:0] oent_ff;
   logic          load_out;
   logic          ans_in, last_in, tfull_in;
   logic [EW-1:0] oent_in;

   assign load_out = mid_emit || cmd.final_emit;

   always_comb begin
      ans_in   = 1'b0;
      last_in  = 1'b1;
      tfull_in = 1'b0;
      oent_in  = '0;
      if (mid_emit) begin
         ans_in  = 1'b1;
         last_in = 1'b0;
         oent_in = pend_ff;
      end else begin
         case (op_ff)
            bsoc_pkg::OP_ADD: begin
               ans_in   = !full;
               tfull_in = full;
            end
            bsoc_pkg::OP_CHECK:  ans_in = bounds_ok_ff && !collide_ff;
            bsoc_pkg::OP_SENSE: begin
               ans_in  = pend_v_ff;
               oent_in = pend_v_ff ? pend_ff : '0;
            end
            bsoc_pkg::OP_EXISTS: ans_in = match_ff;
            default: ans_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         ans_ff   <= ans_in;
         last_ff  <= last_in;
         tfull_ff <= tfull_in;
         oent_ff  <= oent_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_answer       = ans_ff;
   assign rsp_last         = last_ff;
   assign rsp_table_full   = tfull_ff;
   assign rsp_found_x      = oent_ff[CB-1:0];
   assign rsp_found_y      = oent_ff[2*CB-1:CB];
   assign rsp_found_z      = oent_ff[3*CB-1:2*CB];
   assign rsp_found_radius = oent_ff[EW-1:3*CB];

   assign status.adv        = adv;
   assign status.walk_done  = (idx_ff >= count_ff);
   assign status.pipe_empty = !(v0_ff || va_ff || vb_ff || vc_ff);
   assign status.out_free   = out_free;
   assign status.op         = op_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNTW'(MAX_OBSTACLES),
      "obstacle count above table size")
   `ASSERT_IMPLIES(a_final_drained, clock, reset, cmd.final_emit,
      status.pipe_empty && !mid_emit, "final result while pipeline busy")
   `ASSERT_IMPLIES(a_hold_reason, clock, reset, !adv,
      pend_v_ff && rsp_valid && rsp_stall, "pipeline held without a waiting hit")
   `ASSERT_IMPLIES(a_issue_in_range, clock, reset, cmd.issue,
      idx_ff < count_ff, "table read beyond stored obstacles")
endmodule

// ===== src/box_sphere_obstacle_checker_core.sv =====
// Top level of the box/sphere obstacle checker.
// Depends on bsoc_pkg, bsoc_ctrl, bsoc_dp and bsoc_ram.
`timescale 1ns / 1ps
// An add passes from acceptance through the walk and final states to the output register
// without reading the table. A validity check, sense or exists request reads the stored
// obstacles from the table RAM one per cycle, while the walk is not held, through a
// four-stage distance pipeline. A sense request delivers each hit as it is found, one
// behind, and holds the walk when a further hit arrives while the result channel stalls.
// The next request is accepted once the final result is loaded.
module box_sphere_obstacle_checker_core #(
   parameter int MAX_OBSTACLES = bsoc_pkg::MaxObstacles,
   parameter int COORD_BITS    = bsoc_pkg::CoordBits
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_operation,
   input  logic signed [COORD_BITS-1:0]      req_pos_x,
   input  logic signed [COORD_BITS-1:0]      req_pos_y,
   input  logic signed [COORD_BITS-1:0]      req_pos_z,
   input  logic [COORD_BITS-2:0]             req_radius_in,
   input  logic [COORD_BITS-2:0]             req_half_width_x,
   input  logic [COORD_BITS-2:0]             req_half_width_y,
   input  logic [COORD_BITS-2:0]             req_half_width_z,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_answer,
   output logic signed [COORD_BITS-1:0]      rsp_found_x,
   output logic signed [COORD_BITS-1:0]      rsp_found_y,
   output logic signed [COORD_BITS-1:0]      rsp_found_z,
   output logic [COORD_BITS-2:0]             rsp_found_radius,
   output logic                              rsp_last,
   output logic                              rsp_table_full,
   input  logic                              csr_write_enable,
   input  logic [bsoc_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [COORD_BITS-1:0]             csr_write_data
);
   bsoc_pkg::cmd_type    cmd;
   bsoc_pkg::status_type status;

   bsoc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bsoc_dp #(.MAX_OBSTACLES(MAX_OBSTACLES), .COORD_BITS(COORD_BITS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_operation    (req_operation),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_radius_in    (req_radius_in),
      .req_half_width_x (req_half_width_x),
      .req_half_width_y (req_half_width_y),
      .req_half_width_z (req_half_width_z),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_answer       (rsp_answer),
      .rsp_found_x      (rsp_found_x),
      .rsp_found_y      (rsp_found_y),
      .rsp_found_z      (rsp_found_z),
      .rsp_found_radius (rsp_found_radius),
      .rsp_last         (rsp_last),
      .rsp_table_full   (rsp_table_full),
      .cmd              (cmd),
      .status           (status)
   );
endmodule
